// ===== sv/tempo_clock_transport_assert.svh =====
// Assertion macros used by the transport clock checker.
`ifndef TEMPO_CLOCK_TRANSPORT_ASSERT_SVH
`define TEMPO_CLOCK_TRANSPORT_ASSERT_SVH

// Same-cycle implication, sampled on clk, dropped while rst_n is low.
`define TCT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, dropped while rst_n is low.
`define TCT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/tct_pkg.sv =====
// Types, codes and constants of the transport clock.
`timescale 1ns / 1ps
package tct_pkg;

  localparam int IN_TDATA_W  = 88;
  localparam int OUT_TDATA_W = 104;
  localparam int CMD_W       = 3;
  localparam int TIME_W      = 48;
  localparam int DIVD_W      = 64;
  localparam int DIVS_W      = 32;

  localparam logic [CMD_W-1:0] CMD_QUERY  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PULSE  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_TAP    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_TOGGLE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_TEMPO  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_MODE   = 3'd5;

  localparam logic [DIVD_W-1:0] BPM_NUMERATOR  = 64'd3932160000000;
  localparam logic [31:0]       DEFAULT_PERIOD = 32'd500000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_TAP_SUM,
    ST_TAP_AVG,
    ST_TAP_BPM,
    ST_APPLY,
    ST_APPLY_POS,
    ST_APPLY_PER,
    ST_POS,
    ST_POS_W,
    ST_TEMPO_W,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [DIVS_W-1:0] divisor;
  } div_req_t;

  function automatic logic [31:0] sat32(input logic [63:0] v);
    if (v[63:32] != '0) return '1;
    return v[31:0];
  endfunction

endpackage

// ===== sv/tct_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module tct_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  tct_pkg::div_req_t           req,
  output logic                        done,
  output logic [tct_pkg::DIVD_W-1:0]  quot
);
  import tct_pkg::*;

  localparam int CNT_W = $clog2(DIVD_W);

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [DIVD_W-1:0] q_r;
  logic [DIVS_W-1:0] rem_r;
  logic [DIVS_W-1:0] dsr_r;
  logic [DIVS_W:0]   rem_sh;
  logic [DIVS_W:0]   diff;
  logic              ge;

  always_comb begin
    rem_sh = {rem_r, q_r[DIVD_W-1]};
    ge     = rem_sh >= {1'b0, dsr_r};
    diff   = rem_sh - {1'b0, dsr_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        q_r    <= req.dividend;
        rem_r  <= '0;
        dsr_r  <= req.divisor;
      end else if (busy_r) begin
        // shift in the next dividend bit, subtract where it fits
        q_r   <= {q_r[DIVD_W-2:0], ge};
        rem_r <= ge ? diff[DIVS_W-1:0] : rem_sh[DIVS_W-1:0];
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(DIVD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

// ===== sv/tempo_clock_transport.sv =====
// Top level of the music transport clock: command sequencer and transport state.
`timescale 1ns / 1ps
// One command transaction in, one result transaction out. The block works on
// one command at a time: every division (beat position, tempo, tap average,
// tap tempo, tempo period) goes through a single shared bit-serial divider
// that yields one quotient bit a cycle. A query, pulse, toggle or mode change
// needs up to two divisions; a set tempo three or four; a tap that updates
// the tempo up to six. Results sit in an output register, so a waiting result
// does not hold up acceptance of the next command, though that command's result
// waits in ST_OUT until the register is free. Position is Q16.16 quarter notes,
// tempo is Q16.16 BPM; a zero tempo request is dropped and flagged.
module tempo_clock_transport #(
  parameter int PULSES_PER_QUARTER = 24,
  parameter int TAP_HISTORY        = 4
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // tuser: cmd[2:0]
  input  logic [tct_pkg::CMD_W-1:0]         in_tuser,
  // tdata: now_us[47:0], new_bpm_q16[79:48], new_mode[80], zero fill
  input  logic [tct_pkg::IN_TDATA_W-1:0]    in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // tdata: position_q16[31:0], bpm_q16[63:32], running[64],
  // reset_count[96:65], clock_source[97], tempo_rejected[98], zero fill
  output logic [tct_pkg::OUT_TDATA_W-1:0]   out_tdata
);
  import tct_pkg::*;

  localparam int PPQ_W  = $clog2(PULSES_PER_QUARTER + 1);
  localparam int MEAS_W = TIME_W + PPQ_W;
  localparam int FILT_W = MEAS_W + 3;
  localparam int SUM_W  = 32 + $clog2(TAP_HISTORY + 1);
  localparam int TCNT_W = $clog2(TAP_HISTORY + 1);
  localparam logic [31:0] POS_STEP = 32'(65536 / PULSES_PER_QUARTER);

  state_t state_r, state_nxt;

  // latched command
  logic [CMD_W-1:0]  cmd_r, cmd_nxt;
  logic [TIME_W-1:0] now_r, now_nxt;
  logic [31:0]       new_bpm_r, new_bpm_nxt;
  logic              new_mode_r, new_mode_nxt;

  // transport state
  logic              src_r, src_nxt;
  logic              int_run_r, int_run_nxt;
  logic              ext_run_r, ext_run_nxt;
  logic              first_r, first_nxt;
  logic [31:0]       int_base_r, int_base_nxt;
  logic [TIME_W-1:0] int_start_r, int_start_nxt;
  logic [31:0]       int_per_r, int_per_nxt;
  logic [TIME_W-1:0] ext_time_r, ext_time_nxt;
  logic [31:0]       ext_pos_r, ext_pos_nxt;
  logic [31:0]       ext_per_r, ext_per_nxt;
  logic [31:0]       restart_r, restart_nxt;
  logic [TIME_W-1:0] tap_time_r, tap_time_nxt;
  logic              tap_seen_r, tap_seen_nxt;
  logic [31:0]       tap_iv_r   [TAP_HISTORY];
  logic [31:0]       tap_iv_nxt [TAP_HISTORY];

  // working registers
  logic              rej_r, rej_nxt;
  logic [31:0]       apply_bpm_r, apply_bpm_nxt;
  logic [31:0]       pos_acc_r, pos_acc_nxt;
  logic [31:0]       per_hold_r, per_hold_nxt;
  logic [31:0]       tempo_r, tempo_nxt;

  // output register
  logic              out_valid_r, out_valid_nxt;
  logic [31:0]       out_pos_r, out_pos_nxt;
  logic [31:0]       out_bpm_r, out_bpm_nxt;
  logic              out_run_r, out_run_nxt;
  logic [31:0]       out_cnt_r, out_cnt_nxt;
  logic              out_src_r, out_src_nxt;
  logic              out_rej_r, out_rej_nxt;

  // combinational helpers
  logic [TIME_W-1:0] int_el, ext_el, sel_el, tap_el;
  logic [MEAS_W-1:0] measured;
  logic [FILT_W-1:0] filt_sum;
  logic [SUM_W-1:0]  tap_sum;
  logic [TCNT_W-1:0] tap_cnt;
  logic [31:0]       sel_base, sel_per;
  logic              sel_known;

  div_req_t          div_req;
  logic              div_done;
  logic [DIVD_W-1:0] div_quot;

  tct_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_rej_r, out_src_r, out_cnt_r, out_run_r, out_bpm_r, out_pos_r};

  always_comb begin
    // elapsed times wrap modulo 2^48
    int_el   = now_r - int_start_r;
    ext_el   = now_r - ext_time_r;
    tap_el   = now_r - tap_time_r;
    measured = MEAS_W'(ext_el) * MEAS_W'(PULSES_PER_QUARTER);
    filt_sum = FILT_W'(ext_per_r) * FILT_W'(7) + FILT_W'(measured);

    tap_sum = '0;
    tap_cnt = '0;
    for (int i = 0; i < TAP_HISTORY; i++) begin
      if (tap_iv_r[i] != '0) begin
        tap_sum = tap_sum + SUM_W'(tap_iv_r[i]);
        tap_cnt = tap_cnt + TCNT_W'(1);
      end
    end

    if (!src_r) begin
      sel_base  = int_base_r;
      sel_el    = int_el;
      sel_per   = int_per_r;
      sel_known = 1'b1;
    end else begin
      sel_base  = ext_pos_r;
      sel_el    = ext_el;
      sel_per   = ext_per_r;
      sel_known = first_r;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    now_nxt       = now_r;
    new_bpm_nxt   = new_bpm_r;
    new_mode_nxt  = new_mode_r;
    src_nxt       = src_r;
    int_run_nxt   = int_run_r;
    ext_run_nxt   = ext_run_r;
    first_nxt     = first_r;
    int_base_nxt  = int_base_r;
    int_start_nxt = int_start_r;
    int_per_nxt   = int_per_r;
    ext_time_nxt  = ext_time_r;
    ext_pos_nxt   = ext_pos_r;
    ext_per_nxt   = ext_per_r;
    restart_nxt   = restart_r;
    tap_time_nxt  = tap_time_r;
    tap_seen_nxt  = tap_seen_r;
    tap_iv_nxt    = tap_iv_r;
    rej_nxt       = rej_r;
    apply_bpm_nxt = apply_bpm_r;
    pos_acc_nxt   = pos_acc_r;
    per_hold_nxt  = per_hold_r;
    tempo_nxt     = tempo_r;
    out_valid_nxt = out_valid_r;
    out_pos_nxt   = out_pos_r;
    out_bpm_nxt   = out_bpm_r;
    out_run_nxt   = out_run_r;
    out_cnt_nxt   = out_cnt_r;
    out_src_nxt   = out_src_r;
    out_rej_nxt   = out_rej_r;
    div_req       = '0;

    // drop the result once taken
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt      = in_tuser;
          now_nxt      = in_tdata[47:0];
          new_bpm_nxt  = in_tdata[79:48];
          new_mode_nxt = in_tdata[80];
          rej_nxt      = 1'b0;
          state_nxt    = ST_EXEC;
        end
      end

      ST_EXEC: begin
        state_nxt = ST_POS;
        unique case (cmd_r)
          CMD_QUERY: begin
            state_nxt = ST_POS;
          end
          CMD_PULSE: begin
            if (src_r) begin
              if (!first_r) begin
                first_nxt   = 1'b1;
                ext_run_nxt = 1'b1;
                ext_per_nxt = DEFAULT_PERIOD;
                ext_pos_nxt = '0;
              end else begin
                // 7/8 low-pass on the measured quarter-note period
                ext_per_nxt = sat32(64'(filt_sum >> 3));
                ext_pos_nxt = ext_pos_r + POS_STEP;
              end
              ext_time_nxt = now_r;
            end
          end
          CMD_TAP: begin
            if (!src_r) begin
              if (tap_seen_r) begin
                for (int i = 1; i < TAP_HISTORY; i++) begin
                  tap_iv_nxt[i] = tap_iv_r[i-1];
                end
                tap_iv_nxt[0] = sat32({16'b0, tap_el});
                state_nxt     = ST_TAP_SUM;
              end
              tap_time_nxt = now_r;
              tap_seen_nxt = 1'b1;
            end
          end
          CMD_TOGGLE: begin
            if (!src_r) begin
              int_run_nxt = !int_run_r;
              if (!int_run_r) begin
                int_base_nxt  = '0;
                int_start_nxt = now_r;
                restart_nxt   = restart_r + 32'd1;
              end
            end
          end
          CMD_TEMPO: begin
            if (new_bpm_r == '0) begin
              rej_nxt = 1'b1;
            end else begin
              apply_bpm_nxt = new_bpm_r;
              state_nxt     = ST_APPLY;
            end
          end
          CMD_MODE: begin
            if (!new_mode_r) begin
              int_run_nxt   = 1'b1;
              int_base_nxt  = '0;
              int_start_nxt = now_r;
            end else begin
              first_nxt    = 1'b0;
              ext_run_nxt  = 1'b0;
              ext_per_nxt  = DEFAULT_PERIOD;
              ext_time_nxt = now_r;
              ext_pos_nxt  = '0;
            end
            restart_nxt = restart_r + 32'd1;
            src_nxt     = new_mode_r;
          end
          default: begin
            state_nxt = ST_POS;
          end
        endcase
      end

      ST_TAP_SUM: begin
        if (tap_cnt != '0) begin
          div_req.start    = 1'b1;
          div_req.dividend = DIVD_W'(tap_sum);
          div_req.divisor  = DIVS_W'(tap_cnt);
          state_nxt        = ST_TAP_AVG;
        end else begin
          state_nxt = ST_POS;
        end
      end

      ST_TAP_AVG: begin
        if (div_done) begin
          div_req.start    = 1'b1;
          div_req.dividend = BPM_NUMERATOR;
          div_req.divisor  = div_quot[31:0];
          state_nxt        = ST_TAP_BPM;
        end
      end

      ST_TAP_BPM: begin
        if (div_done) begin
          apply_bpm_nxt = sat32(div_quot);
          state_nxt     = ST_APPLY;
        end
      end

      ST_APPLY: begin
        div_req.start = 1'b1;
        if (int_run_r) begin
          // capture the running position before the period changes
          div_req.dividend = {int_el, 16'b0};
          div_req.divisor  = int_per_r;
          state_nxt        = ST_APPLY_POS;
        end else begin
          div_req.dividend = BPM_NUMERATOR;
          div_req.divisor  = apply_bpm_r;
          state_nxt        = ST_APPLY_PER;
        end
      end

      ST_APPLY_POS: begin
        if (div_done) begin
          int_base_nxt     = int_base_r + div_quot[31:0];
          int_start_nxt    = now_r;
          div_req.start    = 1'b1;
          div_req.dividend = BPM_NUMERATOR;
          div_req.divisor  = apply_bpm_r;
          state_nxt        = ST_APPLY_PER;
        end
      end

      ST_APPLY_PER: begin
        if (div_done) begin
          int_per_nxt = sat32(div_quot);
          state_nxt   = ST_POS;
        end
      end

      ST_POS: begin
        if (!sel_known) begin
          pos_acc_nxt = '0;
          tempo_nxt   = '0;
          state_nxt   = ST_OUT;
        end else if (sel_per == '0) begin
          // a decayed period holds the position at its anchor
          pos_acc_nxt = sel_base;
          tempo_nxt   = '0;
          state_nxt   = ST_OUT;
        end else begin
          pos_acc_nxt      = sel_base;
          per_hold_nxt     = sel_per;
          div_req.start    = 1'b1;
          div_req.dividend = {sel_el, 16'b0};
          div_req.divisor  = sel_per;
          state_nxt        = ST_POS_W;
        end
      end

      ST_POS_W: begin
        if (div_done) begin
          pos_acc_nxt      = pos_acc_r + div_quot[31:0];
          div_req.start    = 1'b1;
          div_req.dividend = BPM_NUMERATOR;
          div_req.divisor  = per_hold_r;
          state_nxt        = ST_TEMPO_W;
        end
      end

      ST_TEMPO_W: begin
        if (div_done) begin
          tempo_nxt = sat32(div_quot);
          state_nxt = ST_OUT;
        end
      end

      ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_pos_nxt   = pos_acc_r;
          out_bpm_nxt   = tempo_r;
          out_run_nxt   = src_r ? ext_run_r : int_run_r;
          out_cnt_nxt   = restart_r;
          out_src_nxt   = src_r;
          out_rej_nxt   = rej_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      src_r       <= 1'b0;
      int_run_r   <= 1'b0;
      ext_run_r   <= 1'b0;
      first_r     <= 1'b0;
      int_base_r  <= '0;
      int_start_r <= '0;
      int_per_r   <= DEFAULT_PERIOD;
      ext_time_r  <= '0;
      ext_pos_r   <= '0;
      ext_per_r   <= DEFAULT_PERIOD;
      restart_r   <= '0;
      tap_time_r  <= '0;
      tap_seen_r  <= 1'b0;
      for (int i = 0; i < TAP_HISTORY; i++) begin
        tap_iv_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      src_r       <= src_nxt;
      int_run_r   <= int_run_nxt;
      ext_run_r   <= ext_run_nxt;
      first_r     <= first_nxt;
      int_base_r  <= int_base_nxt;
      int_start_r <= int_start_nxt;
      int_per_r   <= int_per_nxt;
      ext_time_r  <= ext_time_nxt;
      ext_pos_r   <= ext_pos_nxt;
      ext_per_r   <= ext_per_nxt;
      restart_r   <= restart_nxt;
      tap_time_r  <= tap_time_nxt;
      tap_seen_r  <= tap_seen_nxt;
      tap_iv_r    <= tap_iv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    now_r       <= now_nxt;
    new_bpm_r   <= new_bpm_nxt;
    new_mode_r  <= new_mode_nxt;
    rej_r       <= rej_nxt;
    apply_bpm_r <= apply_bpm_nxt;
    pos_acc_r   <= pos_acc_nxt;
    per_hold_r  <= per_hold_nxt;
    tempo_r     <= tempo_nxt;
    out_pos_r   <= out_pos_nxt;
    out_bpm_r   <= out_bpm_nxt;
    out_run_r   <= out_run_nxt;
    out_cnt_r   <= out_cnt_nxt;
    out_src_r   <= out_src_nxt;
    out_rej_r   <= out_rej_nxt;
  end

endmodule

// ===== sv/tct_checker.sv =====
// Port-level checker for the transport clock and its bind.
`timescale 1ns / 1ps
`include "tempo_clock_transport_assert.svh"
module tct_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [tct_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import tct_pkg::*;

  `TCT_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid, "result dropped while stalled")
  `TCT_ASSERT_NEXT(a_out_stable, out_tvalid && !out_tready, $stable(out_tdata), "stalled result changed")
  `TCT_ASSERT_NEXT(a_one_at_a_time, in_tvalid && in_tready, !in_tready, "second command taken while busy")
  `TCT_ASSERT_SAME(a_ext_idle_zero, out_tvalid && out_tdata[97] && !out_tdata[64], out_tdata[63:0] == '0, "external clock without pulse reports position or tempo")

endmodule

bind tempo_clock_transport tct_checker u_tct_checker (.*);
